[rtl/core/clcd_pkg.sv]
// Shared types, command codes and the LCD sequence table for the nibble interface.
package clcd_pkg;

  localparam int StepW  = 6;
  localparam int WaitW  = 16;
  localparam int PulseW = 8;

  // Request codes carried in the cmd field
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_WR_CMD   = 3'd1;
  localparam logic [2:0] CMD_WR_DATA  = 3'd2;
  localparam logic [2:0] CMD_CLEAR    = 3'd3;
  localparam logic [2:0] CMD_INIT     = 3'd4;

  // Entry points into the sequence table
  localparam logic [StepW-1:0] SEQ_WRITE = 6'd0;
  localparam logic [StepW-1:0] SEQ_CLEAR = 6'd3;
  localparam logic [StepW-1:0] SEQ_INIT  = 6'd7;

  localparam logic [PulseW-1:0] PULSE_RESET = 8'd1;

  typedef enum logic [2:0] {
    OP_NIB  = 3'd0,
    OP_HI   = 3'd1,
    OP_LO   = 3'd2,
    OP_WAIT = 3'd3,
    OP_END  = 3'd4
  } seq_op_t;

  typedef struct packed {
    seq_op_t          op;
    logic [WaitW-1:0] arg;
  } seq_entry_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic       e_pin;
    logic       rs_pin;
    logic [3:0] data_nibble;
    logic       busy_res;
    logic       rejected;
  } out_item_t;

  function automatic seq_entry_t seq_lookup(input logic [StepW-1:0] idx);
    seq_entry_t e;
    e.op  = OP_END;
    e.arg = '0;
    unique case (idx)
      6'd0:  e.op = OP_HI;
      6'd1:  e.op = OP_LO;
      6'd2:  e.op = OP_END;
      6'd3:  e.op = OP_HI;
      6'd4:  e.op = OP_LO;
      6'd5:  begin e.op = OP_WAIT; e.arg = 16'd2000;  end
      6'd6:  e.op = OP_END;
      6'd7:  begin e.op = OP_WAIT; e.arg = 16'd40000; end
      6'd8:  begin e.op = OP_NIB;  e.arg = 16'h3;     end
      6'd9:  begin e.op = OP_WAIT; e.arg = 16'd6000;  end
      6'd10: begin e.op = OP_NIB;  e.arg = 16'h3;     end
      6'd11: begin e.op = OP_WAIT; e.arg = 16'd300;   end
      6'd12: begin e.op = OP_NIB;  e.arg = 16'h3;     end
      6'd13: begin e.op = OP_WAIT; e.arg = 16'd2000;  end
      6'd14: begin e.op = OP_NIB;  e.arg = 16'h2;     end
      6'd15: begin e.op = OP_WAIT; e.arg = 16'd2000;  end
      6'd16: begin e.op = OP_NIB;  e.arg = 16'h2;     end
      6'd17: begin e.op = OP_NIB;  e.arg = 16'h8;     end
      6'd18: begin e.op = OP_NIB;  e.arg = 16'h0;     end
      6'd19: begin e.op = OP_NIB;  e.arg = 16'hC;     end
      6'd20: begin e.op = OP_NIB;  e.arg = 16'h0;     end
      6'd21: begin e.op = OP_NIB;  e.arg = 16'h1;     end
      6'd22: begin e.op = OP_NIB;  e.arg = 16'h0;     end
      6'd23: begin e.op = OP_NIB;  e.arg = 16'h6;     end
      default: e.op = OP_END;
    endcase
    return e;
  endfunction

endpackage

[rtl/core/clcd_sequencer.sv]
// Sequencer state and step logic for the LCD nibble interface.
module clcd_sequencer
  import clcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        fire,
  input  in_item_t    item,
  output out_item_t   result
);

  logic [PulseW-1:0] pulse_r;
  logic [StepW-1:0]  step_r, step_nxt;
  logic [WaitW-1:0]  wait_r, wait_nxt;
  logic [7:0]        held_r, held_nxt;
  logic              rs_r, rs_nxt;
  logic              e_r, e_nxt;
  logic [3:0]        bus_r, bus_nxt;
  logic              busy_r, busy_nxt;

  logic              is_req;
  logic              rej;
  logic              start;
  logic [StepW-1:0]  start_idx;
  logic [WaitW-1:0]  pulse_len;
  logic [WaitW-1:0]  wait_dec;
  seq_entry_t        ent;

  // A zero pulse length counts as one tick
  assign pulse_len = (pulse_r == '0) ? WaitW'(1) : WaitW'(pulse_r);
  assign wait_dec  = (wait_r != '0) ? wait_r - WaitW'(1) : '0;
  assign is_req    = (item.cmd == CMD_WR_CMD) || (item.cmd == CMD_WR_DATA) ||
                     (item.cmd == CMD_CLEAR)  || (item.cmd == CMD_INIT);
  assign ent       = seq_lookup(start_idx);

  always_comb begin
    step_nxt  = step_r;
    wait_nxt  = wait_r;
    held_nxt  = held_r;
    rs_nxt    = rs_r;
    e_nxt     = e_r;
    bus_nxt   = bus_r;
    busy_nxt  = busy_r;
    rej       = 1'b0;
    start     = 1'b0;
    start_idx = '0;

    if (fire) begin
      if (is_req) begin
        if (busy_r) begin
          rej = 1'b1;
        end else begin
          busy_nxt = 1'b1;
          start    = 1'b1;
          priority if (item.cmd == CMD_CLEAR) begin
            held_nxt  = 8'h01;
            rs_nxt    = 1'b0;
            start_idx = SEQ_CLEAR;
          end else if (item.cmd == CMD_INIT) begin
            rs_nxt    = 1'b0;
            bus_nxt   = 4'h0;
            start_idx = SEQ_INIT;
          end else begin
            held_nxt  = item.value;
            rs_nxt    = (item.cmd == CMD_WR_DATA);
            start_idx = SEQ_WRITE;
          end
        end
      end else if (busy_r) begin
        // Count one tick off the current phase
        wait_nxt = wait_dec;
        if (wait_dec == '0) begin
          if (e_r) begin
            e_nxt    = 1'b0;
            wait_nxt = pulse_len;
          end else begin
            start     = 1'b1;
            start_idx = step_r + StepW'(1);
          end
        end
      end
    end

    if (start) begin
      step_nxt = start_idx;
      unique case (ent.op)
        OP_NIB, OP_HI, OP_LO: begin
          priority if (ent.op == OP_NIB) bus_nxt = ent.arg[3:0];
          else if (ent.op == OP_HI)      bus_nxt = held_nxt[7:4];
          else                           bus_nxt = held_nxt[3:0];
          e_nxt    = 1'b1;
          wait_nxt = pulse_len;
        end
        OP_WAIT: begin
          e_nxt    = 1'b0;
          wait_nxt = ent.arg;
        end
        default: begin
          e_nxt    = 1'b0;
          wait_nxt = '0;
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    result.e_pin       = e_nxt;
    result.rs_pin      = rs_nxt;
    result.data_nibble = bus_nxt;
    result.busy_res    = busy_nxt;
    result.rejected    = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r <= PULSE_RESET;
      step_r  <= '0;
      wait_r  <= '0;
      held_r  <= '0;
      rs_r    <= 1'b0;
      e_r     <= 1'b0;
      bus_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      if (cfg_we) pulse_r <= cfg_wdata;
      step_r <= step_nxt;
      wait_r <= wait_nxt;
      held_r <= held_nxt;
      rs_r   <= rs_nxt;
      e_r    <= e_nxt;
      bus_r  <= bus_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

[rtl/core/clcd_out_reg.sv]
// Result register for the LCD nibble interface output channel.
module clcd_out_reg
  import clcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data
);

  logic      valid_r, valid_nxt;
  out_item_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load)            valid_nxt = 1'b1;
    else if (!out_stall) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= load_data;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[rtl/core/char_lcd_nibble_interface_unit.sv]
// Top level of the 4-bit character LCD interface: sequencer plus result register.
//
//   channel  direction  handshake             beat
//   in_      input      in_valid / in_stall   in_item_t  {cmd, value}
//   out_     output     out_valid / out_stall out_item_t {e_pin, rs_pin, data_nibble,
//                                                         busy_res, rejected}
//   cfg_     input      cfg_we (no wait)      cfg_wdata = e_pulse_ticks
//
// The sequencer updates its state and the result register loads on the same
// edge, so one beat is accepted per cycle while in_stall is low.
// Each input beat yields one output beat, which appears in out_data in the next cycle.
// in_stall is high only while a result waits in the register and the far side stalls.
// Reset (synchronous, rst_n low) idles the sequencer, clears all bus levels
// and sets e_pulse_ticks to one; the output register comes up empty.
module char_lcd_nibble_interface_unit
  import clcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic      in_fire;
  out_item_t step_res;

  // Hold the input side only while a finished beat is stuck in the result register
  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // Advance the LCD sequence by one beat
  clcd_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (in_fire),
    .item      (in_data),
    .result    (step_res)
  );

  // Register the pin levels for the output channel
  clcd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .load_data (step_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Every accepted beat shows up as a result on the next cycle
  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("accepted beat produced no result");

  // A rejected request never clears the busy indication
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.rejected) |-> out_data.busy_res)
    else $error("rejected request while not busy");

  // Enable is low whenever the sequencer is idle
  a_idle_e_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.busy_res) |-> !out_data.e_pin)
    else $error("enable high while idle");

endmodule

[tb/tb.sv]
// Self-checking testbench for the 4-bit character LCD interface unit.
module tb;
  import clcd_pkg::*;

  // Command codes past CMD_INIT, which the block treats as plain ticks
  localparam logic [2:0] CMD_SPARE5 = 3'd5;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam int HOLD_CYCLES   = 40;    // long receiver hold-off
  localparam int QUIET_LIMIT   = 2000;  // cycles with no beat on either side
  localparam int BLOCK_BEATS   = 185;   // busy beats per random block
  localparam int MAX_REPORTS   = 10;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [2:0] cmd;
    logic [7:0] value;   // byte for a beat, register value for a config row
    bit         drain;   // tick on until the sequence is done
    bit         typed;   // compare against the typed pin levels below
    out_item_t  want;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_we;
  logic [7:0] cfg_wdata;

  char_lcd_nibble_interface_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------
  // LCD sequencer model: bus levels after each accepted beat
  // ---------------------------------------------------------------------
  logic [7:0]  lcd_pulse = PULSE_RESET;
  logic [5:0]  lcd_step  = '0;
  logic [15:0] lcd_wait  = '0;
  logic [7:0]  lcd_held  = '0;
  logic        lcd_rs    = 1'b0;
  logic        lcd_e     = 1'b0;
  logic [3:0]  lcd_bus   = '0;
  logic        lcd_busy  = 1'b0;

  // Write sequence at 0, clear at 3, power-on at 7; anything past the end stops.
  function automatic seq_entry_t lcd_rom(input logic [5:0] idx);
    seq_entry_t ent;
    ent.op  = OP_END;
    ent.arg = '0;
    case (idx)
      6'd0, 6'd3:          ent.op = OP_HI;
      6'd1, 6'd4:          ent.op = OP_LO;
      6'd5, 6'd13, 6'd15:  begin ent.op = OP_WAIT; ent.arg = 16'd2000; end
      6'd7:                begin ent.op = OP_WAIT; ent.arg = 16'd40000; end
      6'd9:                begin ent.op = OP_WAIT; ent.arg = 16'd6000; end
      6'd11:               begin ent.op = OP_WAIT; ent.arg = 16'd300; end
      6'd8, 6'd10, 6'd12:  begin ent.op = OP_NIB; ent.arg = 16'h3; end
      6'd14, 6'd16:        begin ent.op = OP_NIB; ent.arg = 16'h2; end
      6'd17:               begin ent.op = OP_NIB; ent.arg = 16'h8; end
      6'd18, 6'd20, 6'd22: begin ent.op = OP_NIB; ent.arg = 16'h0; end
      6'd19:               begin ent.op = OP_NIB; ent.arg = 16'hC; end
      6'd21:               begin ent.op = OP_NIB; ent.arg = 16'h1; end
      6'd23:               begin ent.op = OP_NIB; ent.arg = 16'h6; end
      default:             ent.op = OP_END;
    endcase
    return ent;
  endfunction

  // A zero setting still gives a one-tick enable phase.
  function automatic logic [15:0] lcd_pulse_len();
    return (lcd_pulse == 8'd0) ? 16'd1 : {8'd0, lcd_pulse};
  endfunction

  function automatic void lcd_enter(input logic [5:0] idx);
    seq_entry_t ent;
    ent = lcd_rom(idx);
    lcd_step = idx;
    case (ent.op)
      OP_NIB, OP_HI, OP_LO: begin
        if (ent.op == OP_NIB) lcd_bus = ent.arg[3:0];
        else if (ent.op == OP_HI) lcd_bus = lcd_held[7:4];
        else lcd_bus = lcd_held[3:0];
        lcd_e    = 1'b1;
        lcd_wait = lcd_pulse_len();
      end
      OP_WAIT: begin
        lcd_e    = 1'b0;
        lcd_wait = ent.arg;
      end
      default: begin
        lcd_e    = 1'b0;
        lcd_wait = '0;
        lcd_busy = 1'b0;
      end
    endcase
  endfunction

  function automatic out_item_t lcd_predict(input in_item_t beat);
    out_item_t res;
    logic      rej;
    rej = 1'b0;
    if (beat.cmd >= CMD_WR_CMD && beat.cmd <= CMD_INIT) begin
      if (lcd_busy) begin
        rej = 1'b1;
      end else begin
        lcd_busy = 1'b1;
        case (beat.cmd)
          CMD_WR_CMD, CMD_WR_DATA: begin
            lcd_held = beat.value;
            lcd_rs   = (beat.cmd == CMD_WR_DATA);
            lcd_enter(SEQ_WRITE);
          end
          CMD_CLEAR: begin
            lcd_held = 8'h01;
            lcd_rs   = 1'b0;
            lcd_enter(SEQ_CLEAR);
          end
          default: begin
            lcd_rs  = 1'b0;
            lcd_bus = 4'h0;
            lcd_enter(SEQ_INIT);
          end
        endcase
      end
    end else if (lcd_busy) begin
      // one tick off the current phase; roll into the next one when it ends
      if (lcd_wait != 16'd0) lcd_wait = lcd_wait - 16'd1;
      if (lcd_wait == 16'd0) begin
        if (lcd_e) begin
          lcd_e    = 1'b0;
          lcd_wait = lcd_pulse_len();
        end else begin
          lcd_enter(lcd_step + 6'd1);
        end
      end
    end
    res.e_pin       = lcd_e;
    res.rs_pin      = lcd_rs;
    res.data_nibble = lcd_bus;
    res.busy_res    = lcd_busy;
    res.rejected    = rej;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Scoreboard: predict on input acceptance, compare on output acceptance
  // ---------------------------------------------------------------------
  out_item_t pending_pins[$];   // expected pin levels, oldest first
  bit        typed_on   = 1'b0;
  out_item_t typed_want = '0;

  int n_beats    = 0;
  int live_beats = 0;   // requests, plus busy ticks outside a wait step
  int n_results  = 0;
  int n_rejected = 0;
  int n_inits    = 0;
  int n_clears   = 0;
  int n_cfg      = 0;
  int n_errors   = 0;
  int quiet      = 0;

  always @(posedge clk) begin : scoreboard
    out_item_t  want;
    out_item_t  got;
    out_item_t  res;
    seq_entry_t ent;
    bit         took;
    took = 1'b0;
    if (rst_n) begin
      // Check the output side first so a beat pushed on this edge is never popped here.
      if (out_valid && !out_stall) begin
        took = 1'b1;
        got  = out_data;
        n_results++;
        if (pending_pins.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: result with nothing pending: e=%0b rs=%0b d=%h busy=%0b rej=%0b",
                     $time, got.e_pin, got.rs_pin, got.data_nibble, got.busy_res,
                     got.rejected);
        end else begin
          want = pending_pins.pop_front();
          if (got.e_pin !== want.e_pin || got.rs_pin !== want.rs_pin ||
              got.data_nibble !== want.data_nibble || got.busy_res !== want.busy_res ||
              got.rejected !== want.rejected) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: pin mismatch, expected e=%0b rs=%0b d=%h busy=%0b rej=%0b %s",
                       $time, want.e_pin, want.rs_pin, want.data_nibble, want.busy_res,
                       want.rejected, $sformatf("got e=%0b rs=%0b d=%h busy=%0b rej=%0b",
                       got.e_pin, got.rs_pin, got.data_nibble, got.busy_res, got.rejected));
          end
        end
      end

      if (in_valid && !in_stall) begin
        took = 1'b1;
        n_beats++;
        // count everything but idle ticks and ticks inside a long wait
        ent = lcd_rom(lcd_step);
        if ((in_data.cmd >= CMD_WR_CMD && in_data.cmd <= CMD_INIT) ||
            (lcd_busy && ent.op != OP_WAIT))
          live_beats++;
        res = lcd_predict(in_data);
        if (res.rejected) n_rejected++;
        else if (in_data.cmd == CMD_INIT) n_inits++;
        else if (in_data.cmd == CMD_CLEAR) n_clears++;
        pending_pins.push_back(typed_on ? typed_want : res);
      end
    end

    // Watchdog: end the run if neither side moves for too long.
    if (took) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, quiet);
      $display("tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall, plus one long hold-off on request
  // ---------------------------------------------------------------------
  int in_idle_pct    = 0;
  int out_idle_pct   = 0;
  bit stall_hold_req = 1'b0;
  int hold_left      = 0;

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_hold_req) begin
        stall_hold_req = 1'b0;
        hold_left      = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  row_t dir_rows[$];

  task automatic add_row(input row_kind_t kind, input logic [2:0] cmd, input logic [7:0] value,
                         input bit drain, input bit typed, input out_item_t want);
    row_t r;
    r.kind  = kind;
    r.cmd   = cmd;
    r.value = value;
    r.drain = drain;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  // Offer one beat after a random gap; hold it until it is taken.
  task automatic send_beat(input logic [2:0] cmd, input logic [7:0] value, input bit typed,
                           input out_item_t want);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= {cmd, value};
    typed_on   = typed;
    typed_want = want;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  // Drop valid and wait until every pending result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(negedge clk);
  endtask

  task automatic write_pulse(input logic [7:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    lcd_pulse = v;
    n_cfg++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One request with random content, then ticks (with stray requests and spare codes)
  // until the sequence is done; a few picks are just noise on an idle block.
  task automatic random_sequence(input bit init_ok);
    int         pick;
    logic [2:0] req;
    pick = $urandom_range(99);
    if (pick < 6) begin
      req = (pick < 3) ? CMD_TICK : 3'(CMD_SPARE5 + $urandom_range(2));
      send_beat(req, 8'($urandom_range(255)), 1'b0, '0);
    end else begin
      if (pick < 48) req = CMD_WR_CMD;
      else if (pick < 92) req = CMD_WR_DATA;
      else if (pick < 97 || !init_ok) req = CMD_CLEAR;
      else req = CMD_INIT;
      send_beat(req, 8'($urandom_range(255)), 1'b0, '0);
      while (lcd_busy) begin
        pick = $urandom_range(99);
        if (pick < 5) send_beat(3'(CMD_WR_CMD + $urandom_range(3)), 8'($urandom_range(255)),
                                1'b0, '0);
        else if (pick < 9) send_beat(3'(CMD_SPARE5 + $urandom_range(2)),
                                     8'($urandom_range(255)), 1'b0, '0);
        else send_beat(CMD_TICK, 8'($urandom_range(255)), 1'b0, '0);
      end
    end
  endtask

  initial begin : stimulus
    int         target;
    logic [7:0] pv;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;

    // Directed rows. Typed pins are {e, rs, d7..d4, busy, rejected}.
    add_row(ROW_BEAT, CMD_TICK,    8'h00, 1'b0, 1'b1, {1'b0, 1'b0, 4'h0, 1'b0, 1'b0});
    add_row(ROW_BEAT, CMD_WR_CMD,  8'hA5, 1'b0, 1'b1, {1'b1, 1'b0, 4'hA, 1'b1, 1'b0});
    // requests while busy are dropped and flagged; the bus holds
    add_row(ROW_BEAT, CMD_WR_DATA, 8'h3C, 1'b0, 1'b1, {1'b1, 1'b0, 4'hA, 1'b1, 1'b1});
    add_row(ROW_BEAT, CMD_CLEAR,   8'hFF, 1'b0, 1'b1, {1'b1, 1'b0, 4'hA, 1'b1, 1'b1});
    add_row(ROW_BEAT, CMD_INIT,    8'h00, 1'b0, 1'b1, {1'b1, 1'b0, 4'hA, 1'b1, 1'b1});
    add_row(ROW_BEAT, CMD_TICK,    8'hFF, 1'b1, 1'b0, '0);
    // sequence done: E low, RS and low nibble stay
    add_row(ROW_BEAT, CMD_SPARE5,  8'h00, 1'b0, 1'b1, {1'b0, 1'b0, 4'h5, 1'b0, 1'b0});
    add_row(ROW_BEAT, CMD_WR_DATA, 8'hFF, 1'b1, 1'b1, {1'b1, 1'b1, 4'hF, 1'b1, 1'b0});
    add_row(ROW_BEAT, CMD_WR_DATA, 8'h00, 1'b1, 1'b1, {1'b1, 1'b1, 4'h0, 1'b1, 1'b0});
    add_row(ROW_CFG,  CMD_TICK,    8'd0,  1'b0, 1'b0, '0);
    add_row(ROW_BEAT, CMD_WR_CMD,  8'h0F, 1'b1, 1'b0, '0);
    add_row(ROW_BEAT, CMD_SPARE7,  8'hFF, 1'b0, 1'b1, {1'b0, 1'b0, 4'hF, 1'b0, 1'b0});
    add_row(ROW_BEAT, CMD_CLEAR,   8'h00, 1'b1, 1'b1, {1'b1, 1'b0, 4'h0, 1'b1, 1'b0});
    add_row(ROW_CFG,  CMD_TICK,    8'd255, 1'b0, 1'b0, '0);
    add_row(ROW_BEAT, CMD_WR_DATA, 8'h81, 1'b0, 1'b1, {1'b1, 1'b1, 4'h8, 1'b1, 1'b0});
    add_row(ROW_BEAT, CMD_SPARE6,  8'h7E, 1'b0, 1'b0, '0);
    add_row(ROW_BEAT, CMD_TICK,    8'hFF, 1'b1, 1'b0, '0);
    add_row(ROW_CFG,  CMD_TICK,    8'd1,  1'b0, 1'b0, '0);
    // power-on opens with a wait: E low, RS and bus forced to zero
    add_row(ROW_BEAT, CMD_INIT,    8'hFF, 1'b0, 1'b1, {1'b0, 1'b0, 4'h0, 1'b1, 1'b0});
    add_row(ROW_BEAT, CMD_WR_DATA, 8'h55, 1'b0, 1'b1, {1'b0, 1'b0, 4'h0, 1'b1, 1'b1});
    add_row(ROW_BEAT, CMD_TICK,    8'h00, 1'b1, 1'b0, '0);
    add_row(ROW_BEAT, CMD_WR_CMD,  8'h28, 1'b1, 1'b0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, no idling on either side.
    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_pulse(dir_rows[i].value);
      end else begin
        send_beat(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
        if (dir_rows[i].drain)
          while (lcd_busy) send_beat(CMD_TICK, 8'($urandom_range(255)), 1'b0, '0);
      end
    end

    // Random part: sender-light idling, then receiver-light, then none.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin in_idle_pct = 8;  out_idle_pct = 51; end
        1:       begin in_idle_pct = 51; out_idle_pct = 8;  end
        default: begin in_idle_pct = 0;  out_idle_pct = 0;  end
      endcase
      for (int blk = 0; blk < 2; blk++) begin
        case (ph * 2 + blk)
          2:       pv = 8'd255;
          3:       pv = 8'd0;
          default: pv = 8'($urandom_range(1, 4));
        endcase
        // drain first, so the sender sits out until every result is back
        write_pulse(pv);
        // hold the receiver off while beats keep coming, to back the block up
        if (blk == 0) stall_hold_req = 1'b1;
        target = live_beats + BLOCK_BEATS;
        while (live_beats < target) random_sequence(ph == 2 && blk == 1);
      end
    end

    settle();
    repeat (16) @(negedge clk);
    n_errors += pending_pins.size();

    $display("covered %0d beats (%0d rejected requests, %0d clears, %0d power-on runs)",
             n_beats, n_rejected, n_clears, n_inits);
    $display("checked %0d results over %0d pulse settings including 0, 1 and 255",
             n_results, n_cfg + 1);
    if (n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
